// ----- sv/cbse_pkg.sv -----
`timescale 1ns / 1ps

package cbse_pkg;

  localparam int MAX_COEFS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Reset values of the configuration registers
  localparam logic signed [31:0] X_START_RST     = 32'sd0;
  localparam logic        [31:0] INV_SPACING_RST = 32'h0001_0000;
  localparam logic        [6:0]  COEF_COUNT_RST  = 7'd64;

  // Configuration register indexes
  localparam logic [1:0] REG_X_START     = 2'd0;
  localparam logic [1:0] REG_INV_SPACING = 2'd1;
  localparam logic [1:0] REG_COEF_COUNT  = 2'd2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_t;

  // Control from the pipeline to the banked coefficient table
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [1:0] wr_bank;
  } mem_ctl_t;

  // Table is split into four banks on index bits [1:0]
  function automatic int bank_depth(input int max_coefs);
    return (max_coefs + 3) >> 2;
  endfunction

  function automatic int bank_aw(input int max_coefs);
    int depth;
    depth = (max_coefs + 3) >> 2;
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- sv/cubic_bspline_evaluator.sv -----
// Uniform cubic B-spline evaluator, Q16.16 style fixed point (FRAC_BITS fraction bits).
// Input stream (s_axis_*): each transaction is a load or an evaluate, selected by
// s_axis_tuser. A load writes coef_value into table slot coef_index and gives no result;
// an evaluate returns one result transaction on m_axis_* with the spline value at x_value.
// Every table slot an evaluate touches must have been loaded first.
// Configuration (cfg_*): x_start, inv_spacing, coef_count; write only while the pipe is empty.
// Throughput: one transaction per cycle while the output is not stalled, loads and
// evaluates mixed freely. The rate is set by the coefficient table: the four taps m-3..m
// always fall in four different banks, so each bank's single read port serves one evaluate
// per cycle. Loads write in the same stage where evaluates read, so program order into the
// table is kept with no forwarding.
// Reset (rst, synchronous): configuration returns to x_start 0, inv_spacing 1.0,
// coef_count 64, and the pipeline empties. Table contents are not cleared.
// Stall: when m_axis_tready is low a valid result in the output register holds; each
// stage stalls only when the one after it is full, so bubbles close up and s_axis_tready
// stays high until all nine stages and the output register hold work.
`timescale 1ns / 1ps

module cubic_bspline_evaluator #(
  parameter int MAX_COEFS = cbse_pkg::MAX_COEFS_DEF,
  parameter int FRAC_BITS = cbse_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [5:0] coef_index, [37:6] coef_value,
                                      // [69:38] x_value, [71:70] zero
  input  logic        s_axis_tuser,   // func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] y_value
  output logic [1:0]  m_axis_tuser,   // [0] out_of_span, [1] saturated
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 1;          // u, v, u^2, u^3 in [0, 1.0]
  localparam int UW2  = 2 * UW;
  localparam int KW   = 64 - 2 * F;     // integer part of t - 3
  localparam int WW   = F + 3;          // piece weights, below 8.0
  localparam int PW   = 32 + WW + 1;    // coefficient times weight
  localparam int SW   = PW + 2;         // sum of four products
  localparam int RW   = SW - F;         // rounded sum
  localparam int BAW  = cbse_pkg::bank_aw(MAX_COEFS);

  localparam logic [UW-1:0]  ONE_U   = UW'(1) << F;
  localparam logic [WW-1:0]  ONE_W   = WW'(1) << F;
  localparam logic [UW2-1:0] HALF_U2 = UW2'(1) << (F - 1);
  localparam logic [SW-1:0]  HALF_S  = SW'(1) << (F - 1);
  localparam logic [6:0]     N_CAP   = (MAX_COEFS > 127) ? 7'd127 : 7'(MAX_COEFS);

  // configuration
  logic signed [31:0] x_start;
  logic        [31:0] inv_spacing;
  logic        [6:0]  coef_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start     <= cbse_pkg::X_START_RST;
      inv_spacing <= cbse_pkg::INV_SPACING_RST;
      coef_count  <= cbse_pkg::COEF_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cbse_pkg::REG_X_START:     x_start     <= cfg_data;
        cbse_pkg::REG_INV_SPACING: inv_spacing <= cfg_data;
        cbse_pkg::REG_COEF_COUNT:  coef_count  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // pipeline control: stage k loads when it is empty or its content moves on
  logic [9:1] vld;
  logic [9:1] ld;
  logic       ld_out;
  logic       o_vld;

  always_comb begin
    ld_out = !o_vld || m_axis_tready;
    ld[9]  = !vld[9] || ld_out;
    for (int k = 8; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign s_axis_tready = ld[1];

  // stage registers
  cbse_pkg::func_t    s1_func, s2_func, s3_func, s4_func;
  logic [5:0]         s1_idx, s2_idx, s3_idx, s4_idx;
  logic signed [31:0] s1_cval, s2_cval, s3_cval, s4_cval;
  logic signed [31:0] s1_x;
  logic               s2_neg, s3_neg;
  logic [31:0]        s2_dmag;
  logic [63:0]        s3_prod;
  logic [6:0]         s4_m;
  logic [UW-1:0]      s4_u;
  logic               s4_oos;
  logic [1:0]         s5_mlo;
  logic [UW-1:0]      s5_u, s5_v, s5_squ, s5_sqv;
  logic               s5_oos;
  logic signed [31:0] s6_c [4];
  logic [UW-1:0]      s6_u, s6_v, s6_squ, s6_sqv, s6_cu, s6_cv;
  logic               s6_oos;
  logic signed [31:0] s7_c [4];
  logic [WW-1:0]      s7_w [4];
  logic               s7_oos;
  logic signed [PW-1:0] s8_p [4];
  logic               s8_oos;
  logic signed [SW-1:0] s9_sa, s9_sb;
  logic               s9_oos;
  logic [31:0]        o_y;
  logic               o_oos, o_sat;

  // next values
  logic signed [32:0] s2_d_next;
  logic [63:0]        s3_prod_next;
  logic [6:0]         n_eff, nm3;
  logic [KW-1:0]      k_int;
  logic [F-1:0]       frac;
  logic               k_eq, k_gt;
  logic [6:0]         s4_m_next;
  logic [UW-1:0]      s4_u_next;
  logic               s4_oos_next;
  logic [UW-1:0]      s5_v_next;
  logic [UW2-1:0]     sq_u_full, sq_v_full, cu_full, cv_full;
  logic [WW-1:0]      mid_u, mid_v;
  logic signed [SW-1:0] sum_full;
  logic [RW-1:0]      rnd;
  logic               ovf;

  // coefficient table interface
  cbse_pkg::mem_ctl_t        mem_ctl;
  logic [BAW-1:0]            wr_addr;
  logic [3:0][BAW-1:0]       rd_addr;
  logic [31:0]               rd_data [4];

  // stage 2: offset from the first node
  assign s2_d_next = {s1_x[31], s1_x} - {x_start[31], x_start};

  // stage 3: t - 3 = (x - x_start) * inv_spacing, exact
  assign s3_prod_next = s2_dmag * inv_spacing;

  // stage 4: span check, segment index m and fraction u
  always_comb begin
    if (coef_count < 7'd4) begin
      n_eff = 7'd4;
    end else if (coef_count > N_CAP) begin
      n_eff = N_CAP;
    end else begin
      n_eff = coef_count;
    end
    nm3   = n_eff - 7'd3;
    k_int = s3_prod[63:2*F];
    frac  = s3_prod[2*F-1:F];
    k_eq  = (k_int == KW'(nm3));
    k_gt  = (k_int > KW'(nm3));
    s4_oos_next = s3_neg || k_gt || (k_eq && (frac != '0));
    if (s4_oos_next) begin
      s4_m_next = 7'd3;
      s4_u_next = '0;
    end else if (k_eq) begin
      // right end of the span: last segment at u = 1
      s4_m_next = n_eff - 7'd1;
      s4_u_next = ONE_U;
    end else begin
      s4_m_next = k_int[6:0] + 7'd3;
      s4_u_next = {1'b0, frac};
    end
  end

  // stage 4 -> 5: table access and squares
  always_comb begin
    logic [6:0] slot;
    slot = '0;
    for (int b = 0; b < 4; b++) begin
      // the one tap among m-3..m that lives in bank b
      slot       = s4_m - ((s4_m - 7'(b)) & 7'd3);
      rd_addr[b] = BAW'(slot >> 2);
    end
    wr_addr         = BAW'(s4_idx >> 2);
    mem_ctl.rd_en   = ld[5];
    mem_ctl.wr_en   = ld[5] && vld[4] && (s4_func == cbse_pkg::FUNC_LOAD)
                      && (int'(s4_idx) < MAX_COEFS);
    mem_ctl.wr_bank = s4_idx[1:0];
    s5_v_next = ONE_U - s4_u;
    sq_u_full = s4_u * s4_u + HALF_U2;
    sq_v_full = s5_v_next * s5_v_next + HALF_U2;
  end

  cbse_coef_banks #(
    .MAX_COEFS (MAX_COEFS)
  ) u_coef_banks (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (s4_cval),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // stage 5 -> 6: cubes
  assign cu_full = s5_squ * s5_u + HALF_U2;
  assign cv_full = s5_sqv * s5_v + HALF_U2;

  // stage 6 -> 7: middle weights 1 + 3u + 3u^2 - 3u^3
  always_comb begin
    mid_u = ONE_W + WW'({s6_u, 1'b0}) + WW'(s6_u) + WW'({s6_squ, 1'b0}) + WW'(s6_squ)
            - WW'({s6_cu, 1'b0}) - WW'(s6_cu);
    mid_v = ONE_W + WW'({s6_v, 1'b0}) + WW'(s6_v) + WW'({s6_sqv, 1'b0}) + WW'(s6_sqv)
            - WW'({s6_cv, 1'b0}) - WW'(s6_cv);
  end

  // output stage: final add, round half up, saturate
  always_comb begin
    sum_full = s9_sa + s9_sb;
    rnd      = sum_full[SW-1:F];
    ovf      = !((&rnd[RW-1:31]) || !(|rnd[RW-1:31]));
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_func <= cbse_pkg::func_t'(s_axis_tuser);
      s1_idx  <= s_axis_tdata[5:0];
      s1_cval <= s_axis_tdata[37:6];
      s1_x    <= s_axis_tdata[69:38];
    end
    if (ld[2]) begin
      s2_func <= s1_func;
      s2_idx  <= s1_idx;
      s2_cval <= s1_cval;
      s2_neg  <= s2_d_next[32];
      s2_dmag <= s2_d_next[31:0];
    end
    if (ld[3]) begin
      s3_func <= s2_func;
      s3_idx  <= s2_idx;
      s3_cval <= s2_cval;
      s3_neg  <= s2_neg;
      s3_prod <= s3_prod_next;
    end
    if (ld[4]) begin
      s4_func <= s3_func;
      s4_idx  <= s3_idx;
      s4_cval <= s3_cval;
      s4_m    <= s4_m_next;
      s4_u    <= s4_u_next;
      s4_oos  <= s4_oos_next;
    end
    if (ld[5]) begin
      s5_mlo <= s4_m[1:0];
      s5_u   <= s4_u;
      s5_v   <= s5_v_next;
      s5_squ <= sq_u_full[2*F:F];
      s5_sqv <= sq_v_full[2*F:F];
      s5_oos <= s4_oos;
    end
    if (ld[6]) begin
      for (int j = 0; j < 4; j++) begin
        // c[m-3+j] sits in bank (m+1+j) mod 4
        s6_c[j] <= rd_data[s5_mlo + 2'(j + 1)];
      end
      s6_u   <= s5_u;
      s6_v   <= s5_v;
      s6_squ <= s5_squ;
      s6_sqv <= s5_sqv;
      s6_cu  <= cu_full[2*F:F];
      s6_cv  <= cv_full[2*F:F];
      s6_oos <= s5_oos;
    end
    if (ld[7]) begin
      for (int j = 0; j < 4; j++) begin
        s7_c[j] <= s6_c[j];
      end
      s7_w[0] <= WW'(s6_cv);
      s7_w[1] <= mid_v;
      s7_w[2] <= mid_u;
      s7_w[3] <= WW'(s6_cu);
      s7_oos  <= s6_oos;
    end
    if (ld[8]) begin
      for (int j = 0; j < 4; j++) begin
        s8_p[j] <= s7_c[j] * $signed({1'b0, s7_w[j]});
      end
      s8_oos <= s7_oos;
    end
    if (ld[9]) begin
      s9_sa  <= SW'(s8_p[0]) + SW'(s8_p[1]) + HALF_S;
      s9_sb  <= SW'(s8_p[2]) + SW'(s8_p[3]);
      s9_oos <= s8_oos;
    end
    if (ld_out) begin
      o_oos <= s9_oos;
      o_sat <= !s9_oos && ovf;
      if (s9_oos) begin
        o_y <= '0;
      end else if (ovf) begin
        o_y <= rnd[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        o_y <= rnd[31:0];
      end
    end
  end

  // valid bits; loads leave the pipe once they have written the table
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      o_vld <= 1'b0;
    end else begin
      if (ld[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= 9; k++) begin
        if (ld[k] && (k != 5)) begin
          vld[k] <= vld[k-1];
        end
      end
      if (ld[5]) begin
        vld[5] <= vld[4] && (s4_func == cbse_pkg::FUNC_EVAL);
      end
      if (ld_out) begin
        o_vld <= vld[9];
      end
    end
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = o_y;
  assign m_axis_tuser  = {o_sat, o_oos};

endmodule

// ----- sv/cbse_coef_banks.sv -----
`timescale 1ns / 1ps

// Four single-port-read banks; one write per cycle, registered reads.
module cbse_coef_banks #(
  parameter int MAX_COEFS = cbse_pkg::MAX_COEFS_DEF
) (
  input  logic                                          clk,
  input  cbse_pkg::mem_ctl_t                            ctl,
  input  logic [cbse_pkg::bank_aw(MAX_COEFS)-1:0]       wr_addr,
  input  logic [31:0]                                   wr_data,
  input  logic [3:0][cbse_pkg::bank_aw(MAX_COEFS)-1:0]  rd_addr,
  output logic [31:0]                                   rd_data [4]
);

  localparam int BD = cbse_pkg::bank_depth(MAX_COEFS);

  logic [31:0] mem [4][BD];

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (ctl.wr_en && (ctl.wr_bank == 2'(b))) begin
        mem[b][wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
        rd_data[b] <= mem[b][rd_addr[b]];
      end
    end
  end

endmodule

// ----- sv/cbse_checker.sv -----
`timescale 1ns / 1ps

module cbse_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // no result in flight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // outside the span: value zero, no clipping
  a_oos_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 32'h0) && !m_axis_tuser[1])
    else $error("out-of-span result not zero");

  // clipped result sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000))
    else $error("saturated result not at a limit");

endmodule

bind cubic_bspline_evaluator cbse_checker u_cbse_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/cbse_result_monitor.sv -----
`timescale 1ns / 1ps

module cbse_result_monitor
  import cbse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam int     FB      = FRAC_BITS_DEF;
  localparam longint ONE_FX  = longint'(1) << FB;
  localparam longint HALF_FX = longint'(1) << (FB - 1);
  localparam longint Y_MAX   = 64'sd2147483647;
  localparam longint Y_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] y_value;
    logic        out_of_span;
    logic        saturated;
  } spline_out_t;

  // local copy of the configuration and the coefficient table
  logic signed [31:0] x_org;
  logic [31:0]        inv_h;
  logic [6:0]         n_coefs;
  longint             coef_mem [MAX_COEFS_DEF];

  spline_out_t want_q[$];
  spline_out_t got, want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic longint sq_fx(input longint u);
    return (u * u + HALF_FX) >>> FB;
  endfunction

  function automatic longint cube_fx(input longint u);
    return (sq_fx(u) * u + HALF_FX) >>> FB;
  endfunction

  function automatic longint mid_fx(input longint u);
    return ONE_FX + 3 * u + 3 * sq_fx(u) - 3 * cube_fx(u);
  endfunction

  function automatic spline_out_t eval_spline(input logic signed [31:0] xv);
    spline_out_t r;
    longint      d, n, u, v, sum, y;
    logic [63:0] prod, k;
    int          m;
    r.y_value     = '0;
    r.out_of_span = 1'b1;
    r.saturated   = 1'b0;
    n = longint'(n_coefs);
    if (n < 4) n = 4;
    if (n > MAX_COEFS_DEF) n = MAX_COEFS_DEF;
    d = longint'(xv) - longint'(x_org);
    if (d < 0) return r;
    prod = 64'(d) * {32'd0, inv_h};
    k = prod >> (2 * FB);
    u = longint'((prod >> FB) & 64'(ONE_FX - 1));
    if (k > 64'(n - 3)) return r;
    if (k == 64'(n - 3)) begin
      // end of the span: last segment at u = 1
      if (u != 0) return r;
      m = int'(n) - 1;
      u = ONE_FX;
    end else begin
      m = int'(k) + 3;
    end
    v = ONE_FX - u;
    sum = coef_mem[m] * cube_fx(u) + coef_mem[m - 1] * mid_fx(u)
        + coef_mem[m - 2] * mid_fx(v) + coef_mem[m - 3] * cube_fx(v);
    y = (sum + HALF_FX) >>> FB;
    r.out_of_span = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      r.saturated = 1'b1;
    end else if (y < Y_MIN) begin
      y = Y_MIN;
      r.saturated = 1'b1;
    end
    r.y_value = y[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      x_org   = X_START_RST;
      inv_h   = INV_SPACING_RST;
      n_coefs = COEF_COUNT_RST;
      want_q.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_X_START:     x_org   = cfg_data;
          REG_INV_SPACING: inv_h   = cfg_data;
          REG_COEF_COUNT:  n_coefs = cfg_data[6:0];
          default: ;
        endcase
      end
      // retire the result first so a same-edge evaluate cannot mask an extra result
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
        if (want_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result y=%h oos=%b sat=%b", $realtime,
                     got.y_value, got.out_of_span, got.saturated);
          mismatches++;
        end else begin
          want = want_q.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("%0t: result mismatch exp y=%h oos=%b sat=%b got y=%h oos=%b sat=%b",
                       $realtime, want.y_value, want.out_of_span, want.saturated,
                       got.y_value, got.out_of_span, got.saturated);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (func_t'(s_axis_tuser) == FUNC_LOAD)
          coef_mem[s_axis_tdata[5:0]] = longint'($signed(s_axis_tdata[37:6]));
        else
          want_q.push_back(eval_spline(s_axis_tdata[69:38]));
      end
      pending = want_q.size();
    end
  end

endmodule

// ----- tb/sv/cubic_bspline_evaluator_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the B-spline evaluator. The monitor beside the block
// predicts every result and counts mismatches; this module drives the stimulus.
module cubic_bspline_evaluator_tb;
  import cbse_pkg::*;

  // settle longer than the block latency before touching config
  localparam int DRAIN_CYCLES = 14;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // [5:0] coef_index, [37:6] coef_value, [69:38] x_value
  logic        s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // [31:0] y_value
  logic [1:0]  m_axis_tuser;   // [0] out_of_span, [1] saturated
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors;
  int pending;

  // traffic shaping state
  bit tx_steady;
  bit rx_steady;
  int burst_left;
  int stall_left = 0;
  int run_left   = 0;

  // configuration currently programmed, used to aim x at the knot span
  logic signed [31:0] cur_xs;
  logic [31:0]        cur_inv;
  logic [6:0]         cur_cnt;

  always #5 clk = ~clk;

  cubic_bspline_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cbse_result_monitor result_mon (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (errors),
    .pending       (pending)
  );

  // Receiver: runs of ready alternate with stalls of random length. In steady
  // mode the stalls collapse to zero, so the result side never backs up.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      m_axis_tready <= 1'b1;
      run_left--;
    end else begin
      m_axis_tready <= 1'b1;
      run_left   = $urandom_range(0, 30);
      stall_left = rx_steady ? 0 : $urandom_range(0, 12);
    end
  end

  // One input transaction. Entered and left at a falling edge. The sender works
  // in bursts; outside steady mode tvalid may drop for a random gap between bursts.
  task automatic push_item(input func_t f, input logic [5:0] idx,
                           input logic [31:0] cv, input logic [31:0] xv);
    int gap;
    if (burst_left == 0) begin
      gap = (!tx_steady && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {2'b00, xv, cv, idx};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    @(negedge clk);
  endtask

  // x field is don't-care for a load, but random bits keep it toggling
  task automatic load_coef(input logic [5:0] idx, input logic [31:0] cv);
    push_item(FUNC_LOAD, idx, cv, $urandom);
  endtask

  task automatic eval_at(input logic [31:0] xv);
    push_item(FUNC_EVAL, 6'($urandom_range(0, 63)), $urandom, xv);
  endtask

  // Hold off the sender until every predicted result has come out, then give
  // trailing loads time to leave the pipe.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Config is written only with the pipe empty
  task automatic program_regs(input logic [31:0] xs, input logic [31:0] inv,
                              input logic [6:0] cnt);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_X_START;
    cfg_data  <= xs;
    @(negedge clk);
    cfg_index <= REG_INV_SPACING;
    cfg_data  <= inv;
    @(negedge clk);
    cfg_index <= REG_COEF_COUNT;
    cfg_data  <= {25'd0, cnt};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_xs  = xs;
    cur_inv = inv;
    cur_cnt = cnt;
  endtask

  // Coefficients: mostly full range, some small, some at the extremes so
  // that saturation turns up now and then.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 19))
      0:             return 32'h7FFF_FFFF;
      1:             return 32'h8000_0000;
      2, 3, 4, 5, 6: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default:       return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(0, 3))
      0:       return 32'd1 << $urandom_range(8, 24);
      1:       return $urandom_range(1, 32'h0004_0000);
      2:       return $urandom;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Evaluation points: mostly inside the knot span, some on knots, some just
  // before, at and just past the span end, the rest anywhere.
  function automatic logic [31:0] pick_x();
    longint      n;
    logic [63:0] dmax, hi, d, span_end, lim;
    int          j;
    n = longint'(cur_cnt);
    if (n < 4) n = 4;
    if (n > MAX_COEFS_DEF) n = MAX_COEFS_DEF;
    // distance from x_start to the largest representable x
    hi = 64'(64'sd2147483647 - longint'(cur_xs));
    if (cur_inv == 0) begin
      dmax     = hi;
      span_end = '0;
    end else begin
      dmax     = (64'(n - 3) << 32) / cur_inv;
      span_end = ((64'(n - 3) << 32) + cur_inv - 1) / cur_inv;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        lim = (dmax < hi) ? dmax : hi;
        d = {$urandom, $urandom} % (lim + 1);
      end
      6: begin
        j = $urandom_range(0, int'(n) - 3);
        d = (cur_inv == 0) ? 64'd0 : ((64'(j) << 32) + cur_inv - 1) / cur_inv;
      end
      7: d = span_end + $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
    return 32'(longint'(cur_xs) + longint'(d));
  endfunction

  // A random phase: program, then a mix of loads and evaluates
  task automatic run_phase(input logic [31:0] xs, input logic [31:0] inv,
                           input logic [6:0] cnt, input int items, input bit steady);
    program_regs(xs, inv, cnt);
    tx_steady = steady ? 1'b1 : ($urandom_range(0, 3) == 0);
    rx_steady = steady ? 1'b1 : ($urandom_range(0, 3) == 0);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 3) == 0)
        load_coef(6'($urandom_range(0, 63)), rand_coef());
      else
        eval_at(pick_x());
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    burst_left    = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    cur_xs        = X_START_RST;
    cur_inv       = INV_SPACING_RST;
    cur_cnt       = COEF_COUNT_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the whole table first: the contract forbids reading an unloaded slot
    for (int i = 0; i < MAX_COEFS_DEF; i++)
      load_coef(6'(i), (i == 0) ? 32'h7FFF_FFFF : (i == 1) ? 32'h8000_0000 : rand_coef());

    // Directed part, reset config: x_start 0, h = 1.0, 64 coefs, span [0, 61.0]
    eval_at(32'h0000_0000);   // first node, u = 0
    eval_at(32'h0000_8000);   // half way
    eval_at(32'h0000_FFFF);   // largest fraction
    eval_at(32'h001E_1234);
    eval_at(32'h003D_0000);   // span end exactly, last segment with u = 1
    eval_at(32'h003D_0001);   // one lsb past the end
    eval_at(32'hFFFF_FFFF);   // one lsb below x_start
    eval_at(32'h7FFF_FFFF);
    eval_at(32'h8000_0000);
    // positive clip: all four taps at max
    for (int i = 10; i < 14; i++) load_coef(6'(i), 32'h7FFF_FFFF);
    eval_at(32'h000A_8000);
    // negative clip
    for (int i = 20; i < 24; i++) load_coef(6'(i), 32'h8000_0000);
    eval_at(32'h0014_4000);
    // load immediately followed by a read of the same slot
    load_coef(6'd2, 32'h0001_0000);
    eval_at(32'h0000_0000);

    // Extreme settings: tiny spacing with the fewest coefs, widest spacing
    // with an oversize count, zero inverse spacing with an undersize count
    run_phase(32'h8000_0000, 32'hFFFF_FFFF, 7'd4, 100, 1'b0);
    run_phase(32'h7FFF_FFFF, 32'd1, 7'd127, 100, 1'b1);
    run_phase($urandom, 32'd0, 7'd0, 100, 1'b0);
    run_phase(32'hFFF0_0000, 32'h0001_0000, 7'd64, 175, 1'b0);
    for (int p = 0; p < 7; p++)
      run_phase((p % 2 == 0) ? $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000 : $urandom,
                pick_inv(),
                ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(0, 127)),
                175, 1'b0);

    drain();
    if (errors == 0) begin
      $display("cubic_bspline_evaluator regression: pass");
    end else begin
      $display("cubic_bspline_evaluator regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("cubic_bspline_evaluator regression: fail");
    $finish;
  end

endmodule
